### hw/rtl/epcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epcr_pkg
// Types, codes and helper functions shared by the port register front end.
// ----------------------------------------------------------------------------
package epcr_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_POST  = 2'd3
  } item_cmd_t;

  // register indexes
  localparam logic [1:0] REG_CSR0 = 2'd0;
  localparam logic [1:0] REG_CSR1 = 2'd1;
  localparam logic [1:0] REG_BASE_LO = 2'd2;
  localparam logic [1:0] REG_BASE_HI = 2'd3;

  // port command codes
  localparam logic [3:0] PCMD_NONE      = 4'd0;
  localparam logic [3:0] PCMD_GET_BASE  = 4'd1;
  localparam logic [3:0] PCMD_GET_CMD   = 4'd2;
  localparam logic [3:0] PCMD_SELF_TEST = 4'd3;
  localparam logic [3:0] PCMD_START     = 4'd4;
  localparam logic [3:0] PCMD_POLL      = 4'd8;
  localparam logic [3:0] PCMD_STOP      = 4'd15;

  // port states
  localparam logic [3:0] ST_RESET   = 4'd0;
  localparam logic [3:0] ST_READY   = 4'd2;
  localparam logic [3:0] ST_RUNNING = 4'd3;

  // register 0 bit positions and masks, base register masks and cause bit values
  localparam int unsigned SummaryBit = 7;
  localparam int unsigned EnableBit  = 6;
  localparam int unsigned ResetBit   = 5;
  localparam logic [15:0] CauseMask  = 16'o177400;
  localparam logic [15:0] BaseLoMask = 16'o177776;
  localparam logic [1:0]  BaseHiMask = 2'o3;
  localparam logic [15:0] DoneCause  = 16'o004000;
  localparam logic [15:0] NoBits     = 16'd0;

  typedef struct packed {
    logic [15:0] ctrl;
    logic [3:0]  port_state;
    logic        timeout;
    logic [15:0] base_lo;
    logic [1:0]  base_hi;
    logic        reset_pending;
    logic        cmd_pending;
    logic        irq;
    logic [17:0] block_base;
  } port_state_t;

  typedef struct packed {
    item_cmd_t   command;
    logic [1:0]  reg_select;
    logic        byte_high;
    logic        byte_access;
    logic [15:0] write_data;
    logic [15:0] post_bits;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        interrupt_request;
    logic [17:0] command_block_base;
    logic        start_request;
    logic        stop_request;
    logic [3:0]  dispatch_code;
  } result_t;

  // state right after reset
  function automatic port_state_t reset_value();
    port_state_t r;
    r = '0;
    r.reset_pending = 1'b1;
    return r;
  endfunction

  // reset sequence: everything cleared except the interrupt line, with a reset left pending
  function automatic port_state_t start_reset(port_state_t s);
    port_state_t r;
    r = reset_value();
    r.irq = s.irq;
    return r;
  endfunction

  // set causes and the timeout flag, refresh summary and, when enabled, the interrupt line
  function automatic port_state_t irq_update(port_state_t s, logic [15:0] bits);
    port_state_t r;
    r = s;
    r.timeout = bits[0];
    r.ctrl = r.ctrl | (bits & CauseMask);
    r.ctrl[SummaryBit] = |(r.ctrl & CauseMask);
    if (r.ctrl[EnableBit]) begin
      r.irq = r.ctrl[SummaryBit];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/epcr_logic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epcr_logic
// Next-state and result logic for one item: register reads and writes,
// service ticks and interrupt posting.
// ----------------------------------------------------------------------------
module epcr_logic (
  input  wire epcr_pkg::port_state_t state,
  input  wire epcr_pkg::item_t       item,
  output epcr_pkg::port_state_t      state_nxt,
  output epcr_pkg::result_t          result
);

  epcr_pkg::port_state_t s;
  epcr_pkg::result_t     res;
  logic [15:0]           data;

  always_comb begin
    s    = state;
    res  = '0;
    data = item.write_data;
    unique case (item.command)
      // register read, byte reads return the whole word
      epcr_pkg::CMD_READ: begin
        unique case (item.reg_select)
          epcr_pkg::REG_CSR0:    res.read_data = s.ctrl;
          epcr_pkg::REG_CSR1:    res.read_data = {8'd0, s.timeout, 3'd0, s.port_state};
          epcr_pkg::REG_BASE_LO: res.read_data = s.base_lo;
          default:               res.read_data = {14'd0, s.base_hi};
        endcase
      end
      // register write
      epcr_pkg::CMD_WRITE: begin
        unique case (item.reg_select)
          epcr_pkg::REG_CSR0: begin
            if (item.byte_access) begin
              data = {8'd0, item.write_data[7:0]};
            end
            if (item.byte_access && item.byte_high) begin
              // upper byte only clears causes
              s.ctrl[15:8] = s.ctrl[15:8] & ~data[7:0];
              s = epcr_pkg::irq_update(s, epcr_pkg::NoBits);
            end else begin
              s.ctrl = s.ctrl & ~(data & epcr_pkg::CauseMask);
              if (data[epcr_pkg::ResetBit]) begin
                s = epcr_pkg::start_reset(s);
              end else begin
                if (s.ctrl[epcr_pkg::EnableBit] != data[epcr_pkg::EnableBit]) begin
                  s.ctrl[epcr_pkg::EnableBit] = ~s.ctrl[epcr_pkg::EnableBit];
                end else begin
                  s.ctrl[3:0] = data[3:0];
                  if (data[3:0] != epcr_pkg::PCMD_NONE) begin
                    s.cmd_pending = 1'b1;
                  end
                end
                s = epcr_pkg::irq_update(s, epcr_pkg::NoBits);
              end
            end
          end
          epcr_pkg::REG_BASE_LO: begin
            if (item.byte_access && item.byte_high) begin
              data = {item.write_data[7:0], s.base_lo[7:0]};
            end else if (item.byte_access) begin
              data = {s.base_lo[15:8], item.write_data[7:0]};
            end
            s.base_lo = data & epcr_pkg::BaseLoMask;
          end
          epcr_pkg::REG_BASE_HI: begin
            // upper byte write leaves the two stored bits alone
            if (!(item.byte_access && item.byte_high)) begin
              s.base_hi = item.write_data[1:0] & epcr_pkg::BaseHiMask;
            end
          end
          default: begin
          end
        endcase
      end
      // service tick
      epcr_pkg::CMD_TICK: begin
        if (s.reset_pending) begin
          s.reset_pending = 1'b0;
          s.port_state    = epcr_pkg::ST_READY;
          s = epcr_pkg::irq_update(s, epcr_pkg::DoneCause);
        end else if (s.cmd_pending) begin
          s.cmd_pending = 1'b0;
          case (s.ctrl[3:0])
            epcr_pkg::PCMD_GET_BASE: begin
              s.block_base = {s.base_hi, s.base_lo};
              s = epcr_pkg::irq_update(s, epcr_pkg::DoneCause);
            end
            epcr_pkg::PCMD_GET_CMD, epcr_pkg::PCMD_POLL: begin
              res.dispatch_code = s.ctrl[3:0];
            end
            epcr_pkg::PCMD_SELF_TEST: begin
              s = epcr_pkg::start_reset(s);
              s = epcr_pkg::irq_update(s, epcr_pkg::NoBits);
            end
            epcr_pkg::PCMD_START: begin
              if (s.port_state != epcr_pkg::ST_RUNNING) begin
                s.port_state = epcr_pkg::ST_RUNNING;
                res.start_request = 1'b1;
              end
              s = epcr_pkg::irq_update(s, epcr_pkg::DoneCause);
            end
            epcr_pkg::PCMD_STOP: begin
              if (s.port_state != epcr_pkg::ST_READY) begin
                s.port_state = epcr_pkg::ST_READY;
                res.stop_request = 1'b1;
              end
              s = epcr_pkg::irq_update(s, epcr_pkg::DoneCause);
            end
            default: begin
              s = epcr_pkg::irq_update(s, epcr_pkg::DoneCause);
            end
          endcase
        end
      end
      // engine posts interrupt bits
      default: begin
        s = epcr_pkg::irq_update(s, item.post_bits);
      end
    endcase
    res.interrupt_request  = s.irq;
    res.command_block_base = s.block_base;
  end

  assign state_nxt = s;
  assign result    = res;

endmodule
`default_nettype wire

### hw/rtl/ethernet_port_control_registers.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_port_control_registers
// Result: each accepted item's result is registered in the output register.
// Throughput: one item per cycle; the input stalls only while a held result
// is stalled at the output.
// Reset: synchronous rst_n puts the port in its reset state with a reset
// sequence pending, interrupt line low and the output register empty.
// ----------------------------------------------------------------------------
module ethernet_port_control_registers (
  input  wire         clk,
  input  wire         rst_n,
  // item input
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_command,
  input  wire  [1:0]  in_reg_select,
  input  wire         in_byte_high,
  input  wire         in_byte_access,
  input  wire  [15:0] in_write_data,
  input  wire  [15:0] in_post_bits,
  // result output
  output logic        out_valid,
  input  wire         out_stall,
  output logic [15:0] out_read_data,
  output logic        out_interrupt_request,
  output logic [17:0] out_command_block_base,
  output logic        out_start_request,
  output logic        out_stop_request,
  output logic [3:0]  out_dispatch_code
);

  epcr_pkg::port_state_t state_r;
  epcr_pkg::port_state_t state_nxt;
  epcr_pkg::item_t       item;
  epcr_pkg::result_t     result_nxt;
  epcr_pkg::result_t     result_r;
  logic                  out_valid_r;
  logic                  accept;

  // handshake
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // pack the item
  assign item.command     = epcr_pkg::item_cmd_t'(in_command);
  assign item.reg_select  = in_reg_select;
  assign item.byte_high   = in_byte_high;
  assign item.byte_access = in_byte_access;
  assign item.write_data  = in_write_data;
  assign item.post_bits   = in_post_bits;

  epcr_logic u_logic (
    .state     (state_r),
    .item      (item),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // port state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epcr_pkg::reset_value();
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept | (out_valid_r & out_stall);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_data          = result_r.read_data;
  assign out_interrupt_request  = result_r.interrupt_request;
  assign out_command_block_base = result_r.command_block_base;
  assign out_start_request      = result_r.start_request;
  assign out_stop_request       = result_r.stop_request;
  assign out_dispatch_code      = result_r.dispatch_code;

endmodule
`default_nettype wire
